### sv/slt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants for the sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int KIND_BITS      = 3;
  localparam int VALUE_IN_BITS  = 32;
  localparam int INDEX_BITS     = 4;
  localparam int COUNT_OUT_BITS = 5;
  localparam int STATUS_BITS    = 2;

  // operation codes on the request channel
  typedef enum logic [KIND_BITS-1:0] {
    K_INSERT  = 3'd0,
    K_PREPEND = 3'd1,
    K_APPEND  = 3'd2,
    K_REMOVE  = 3'd3,
    K_READ    = 3'd4
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // what every cell does on a clock edge
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_PREPEND,
    OP_APPEND,
    OP_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [INDEX_BITS-1:0] index;
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

endpackage
`default_nettype wire

### sv/slt_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slt_in_if
// Request channel: one list operation per transfer.
// ----------------------------------------------------------------------------
interface slt_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [slt_pkg::KIND_BITS-1:0]     kind;
  logic signed [slt_pkg::VALUE_IN_BITS-1:0] value;
  logic        [slt_pkg::INDEX_BITS-1:0]    index;

  modport source (output valid, kind, value, index, input ready);
  modport sink   (input valid, kind, value, index, output ready);
endinterface
`default_nettype wire

### sv/slt_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slt_out_if
// Result channel: one result per request.
// ----------------------------------------------------------------------------
interface slt_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [slt_pkg::VALUE_IN_BITS-1:0]  read_value;
  logic        [slt_pkg::COUNT_OUT_BITS-1:0] entry_count;
  logic                                     strictly_sorted;
  logic        [slt_pkg::STATUS_BITS-1:0]    status;

  modport source (output valid, read_value, entry_count, strictly_sorted, status,
                  input ready);
  modport sink   (input valid, read_value, entry_count, strictly_sorted, status,
                  output ready);
endinterface
`default_nettype wire

### sv/sorted_list_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_table
// Ordered list of up to DEPTH signed entries held in a row of cells.
// The result is registered from S_EVAL once the output register is free or
// being taken; a new request is accepted only in S_IDLE, not while one is
// being evaluated. The cells update on the transfer edge, and in S_EVAL
// every adjacent pair is checked for order.
// Reset: clears the entry count and the handshake state; entries are not
// cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_list_table #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input wire       clk,
  input wire       rst,
  slt_in_if.sink   req,
  slt_out_if.source rsp
);
  import slt_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = CW + INDEX_BITS;
  localparam int RD_N = (DEPTH < 16) ? DEPTH : 16;
  localparam int IXW  = (RD_N > 1) ? $clog2(RD_N) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic accept, in_ready, load_out;

  logic signed [VALUE_BITS-1:0] value_v;
  logic signed [VALUE_BITS-1:0] entry_w [DEPTH];
  logic [DEPTH:0]               found_w;
  logic [DEPTH-1:0]             pair_w;
  cell_cmd_t                    cmd;

  logic is_add, is_idx, full, oor;
  status_t status_w;
  logic signed [VALUE_BITS-1:0] rd_sel;

  // held between the transfer and the result load
  status_t                         status_hold;
  logic signed [VALUE_IN_BITS-1:0] rd_hold;

  logic                            out_valid;
  logic signed [VALUE_IN_BITS-1:0] out_read;
  logic [COUNT_OUT_BITS-1:0]       out_count;
  logic                            out_sorted;
  status_t                         out_status;

  assign accept  = req.valid && in_ready;
  assign value_v = VALUE_BITS'(req.value);

  assign is_add = (req.kind == K_INSERT) || (req.kind == K_PREPEND) ||
                  (req.kind == K_APPEND);
  assign is_idx = (req.kind == K_REMOVE) || (req.kind == K_READ);
  assign full   = count == DEPTH_C;
  assign oor    = CMPW'(req.index) >= CMPW'(count);
  assign rd_sel = entry_w[req.index[IXW-1:0]];

  always_comb begin
    cmd.index = req.index;
    cmd.op    = OP_NONE;
    status_w  = ST_OK;
    if (is_add && full) status_w = ST_FULL;
    else if (is_idx && oor) status_w = ST_RANGE;
    if (accept && status_w == ST_OK) begin
      priority case (req.kind)
        K_INSERT:  cmd.op = OP_INSERT;
        K_PREPEND: cmd.op = OP_PREPEND;
        K_APPEND:  cmd.op = OP_APPEND;
        K_REMOVE:  cmd.op = OP_REMOVE;
        default:   cmd.op = OP_NONE;
      endcase
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.op == OP_INSERT || cmd.op == OP_PREPEND || cmd.op == OP_APPEND)
      count_next = count + CW'(1);
    else if (cmd.op == OP_REMOVE)
      count_next = count - CW'(1);
  end

  assign found_w[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slt_cell #(
      .POS       (i),
      .VALUE_BITS(VALUE_BITS),
      .CW        (CW)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .value    (value_v),
      .count    (count),
      .left     ((i == 0) ? value_v : entry_w[(i == 0) ? 0 : i - 1]),
      .right    ((i == DEPTH - 1) ? entry_w[i] : entry_w[(i == DEPTH - 1) ? i : i + 1]),
      .found_in (found_w[i]),
      .found_out(found_w[i+1]),
      .pair_ok  (pair_w[i]),
      .entry    (entry_w[i])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EVAL;
      S_EVAL: if (!out_valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // controls
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_EVAL: load_out = !out_valid || rsp.ready;
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_hold <= status_w;
      rd_hold     <= (req.kind == K_READ && status_w == ST_OK) ?
                     VALUE_IN_BITS'(rd_sel) : '0;
    end
    if (load_out) begin
      out_read   <= rd_hold;
      out_count  <= COUNT_OUT_BITS'(count);
      out_sorted <= &pair_w;
      out_status <= status_hold;
    end
  end

  assign req.ready           = in_ready;
  assign rsp.valid           = out_valid;
  assign rsp.read_value      = out_read;
  assign rsp.entry_count     = out_count;
  assign rsp.strictly_sorted = out_sorted;
  assign rsp.status          = out_status;

  // no second transfer before the current result is loaded
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request taken while previous one still evaluating");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above depth");

  a_short_sorted: assert property (@(posedge clk) disable iff (rst)
    load_out && count <= CW'(1) |=> rsp.strictly_sorted)
    else $error("list of at most one entry reported unsorted");

endmodule
`default_nettype wire

### sv/slt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slt_cell
// One list slot: holds an entry, takes a new value or a neighbor's entry,
// passes the insert-position flag down the row and reports its pair check.
// ----------------------------------------------------------------------------
module slt_cell #(
  parameter int POS        = 0,
  parameter int VALUE_BITS = 32,
  parameter int CW         = 5
) (
  input  wire                          clk,
  input  wire slt_pkg::cell_cmd_t      cmd,
  input  wire logic signed [VALUE_BITS-1:0] value,
  input  wire logic [CW-1:0]           count,
  input  wire logic signed [VALUE_BITS-1:0] left,
  input  wire logic signed [VALUE_BITS-1:0] right,
  input  wire logic                    found_in,
  output logic                         found_out,
  output logic                         pair_ok,
  output logic signed [VALUE_BITS-1:0] entry
);
  import slt_pkg::*;

  localparam int CMPW = CW + INDEX_BITS;
  localparam logic [CW-1:0]   POS_CNT = CW'(POS);
  localparam logic [CMPW-1:0] POS_CMP = CMPW'(POS);
  localparam bit IS_HEAD = (POS == 0);

  logic signed [VALUE_BITS-1:0] entry_next;
  logic in_list, at_count, ge_index, stop;

  assign in_list  = POS_CNT < count;
  assign at_count = POS_CNT == count;
  assign ge_index = POS_CMP >= CMPW'(cmd.index);
  // slot whose entry is not below the value, or the tail; the first such slot takes the value
  assign stop      = (in_list && !(entry < value)) || at_count;
  assign found_out = found_in || stop;
  assign pair_ok   = IS_HEAD || !in_list || (left < entry);

  always_comb begin
    entry_next = entry;
    unique case (cmd.op)
      OP_INSERT: begin
        if (found_in) entry_next = left;
        else if (stop) entry_next = value;
      end
      OP_PREPEND: entry_next = IS_HEAD ? value : left;
      OP_APPEND: begin
        if (at_count) entry_next = value;
      end
      OP_REMOVE: begin
        if (ge_index) entry_next = right;
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire
